>>> src/ilb_pkg.sv
// Shared constants, command and result codes, and interface types of the list buffer.
package ilb_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  localparam logic [1:0] MODE_DUMP   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_INS_REJ  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DELETED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_REJ  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_BAD = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DUMP     = 3'd5;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd6;

  // Store access issued by the sequencer; read data is registered and returns in the next cycle.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic              last;
  } res_t;

endpackage

>>> src/ilb_store.sv
// Entry store: one write port and one registered read port.
module ilb_store
  import ilb_pkg::*;
(
  input  logic              clk_i,
  input  mem_req_t          req_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/ilb_ctrl.sv
// Command sequencer: decodes a request and walks the store one entry at a time.
module ilb_ctrl
  import ilb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        mode_i,
  input  logic [POS_W-1:0]  position_i,
  input  logic [DATA_W-1:0] item_value_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output res_t              res_o,
  output mem_req_t          mem_req_o,
  input  logic [DATA_W-1:0] rdata_i
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS_RD = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_INS_PUT = 3'd3;
  localparam logic [2:0] S_FETCH  = 3'd4;
  localparam logic [2:0] S_CAP    = 3'd5;
  localparam logic [2:0] S_SH_RD  = 3'd6;
  localparam logic [2:0] S_SH_WR  = 3'd7;

  logic [2:0]        state_q, state_d;
  logic              emit_q, emit_d;
  logic [1:0]        mode_q, mode_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  res_t              res_q, res_d;

  logic [CMP_W-1:0]  pos_x, cnt_x, idx_x, idx_p1, idx_p2;
  logic [CNT_W-1:0]  idx_m1, idx_inc;
  logic              accept;

  assign pos_x   = CMP_W'(position_i);
  assign cnt_x   = CMP_W'(count_q);
  assign idx_x   = CMP_W'(idx_q);
  assign idx_p1  = idx_x + CMP_W'(1);
  assign idx_p2  = idx_x + CMP_W'(2);
  assign idx_m1  = idx_q - CNT_W'(1);
  assign idx_inc = idx_q + CNT_W'(1);

  // The emit phase is its own flag so the state vector stays three bits.
  assign in_ready_o  = (state_q == S_IDLE) && !emit_q;
  assign accept      = in_valid_i && in_ready_o;
  assign res_valid_o = emit_q;
  assign res_o       = res_q;

  always_comb begin
    state_d   = state_q;
    emit_d    = emit_q;
    mode_d    = mode_q;
    pos_d     = pos_q;
    val_d     = val_q;
    count_d   = count_q;
    idx_d     = idx_q;
    res_d     = res_q;
    mem_req_o = '{we: 1'b0, waddr: idx_q[ADDR_W-1:0], wdata: rdata_i,
                  raddr: idx_q[ADDR_W-1:0]};

    if (emit_q) begin
      if (out_free_i) begin
        emit_d = 1'b0;
        if ((mode_q == MODE_DUMP) && !res_q.last) begin
          idx_d   = idx_inc;
          state_d = S_FETCH;
        end else begin
          state_d = S_IDLE;
        end
      end
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            mode_d = mode_i;
            pos_d  = position_i;
            val_d  = item_value_i;
            res_d  = '{kind: KIND_INS_REJ, pos: position_i, value: '0, last: 1'b1};
            unique case (mode_i)
              MODE_INSERT: begin
                if ((pos_x > cnt_x) || (count_q == CNT_W'(DEPTH))) begin
                  emit_d = 1'b1;
                end else if (pos_x == cnt_x) begin
                  mem_req_o.we    = 1'b1;
                  mem_req_o.waddr = position_i[ADDR_W-1:0];
                  mem_req_o.wdata = item_value_i;
                  count_d         = count_q + CNT_W'(1);
                end else begin
                  idx_d   = count_q;
                  state_d = S_INS_RD;
                end
              end
              MODE_DELETE, MODE_READ: begin
                if (pos_x >= cnt_x) begin
                  res_d.kind = (mode_i == MODE_DELETE) ? KIND_DEL_REJ : KIND_READ_BAD;
                  emit_d     = 1'b1;
                end else begin
                  idx_d   = CNT_W'(position_i);
                  state_d = S_FETCH;
                end
              end
              default: begin
                if (count_q == '0) begin
                  res_d  = '{kind: KIND_EMPTY, pos: '0, value: '0, last: 1'b1};
                  emit_d = 1'b1;
                end else begin
                  idx_d   = '0;
                  state_d = S_FETCH;
                end
              end
            endcase
          end
        end
        S_INS_RD: begin
          mem_req_o.raddr = idx_m1[ADDR_W-1:0];
          state_d         = S_INS_WR;
        end
        S_INS_WR: begin
          mem_req_o.we = 1'b1;
          idx_d        = idx_m1;
          state_d      = (CMP_W'(idx_m1) == CMP_W'(pos_q)) ? S_INS_PUT : S_INS_RD;
        end
        S_INS_PUT: begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = pos_q[ADDR_W-1:0];
          mem_req_o.wdata = val_q;
          count_d         = count_q + CNT_W'(1);
          state_d         = S_IDLE;
        end
        S_FETCH: begin
          state_d = S_CAP;
        end
        S_CAP: begin
          res_d.value = rdata_i;
          res_d.pos   = pos_q;
          res_d.last  = 1'b1;
          if (mode_q == MODE_DELETE) begin
            res_d.kind = KIND_DELETED;
            if (idx_p1 < cnt_x) begin
              state_d = S_SH_RD;
            end else begin
              count_d = count_q - CNT_W'(1);
              emit_d  = 1'b1;
              state_d = S_IDLE;
            end
          end else if (mode_q == MODE_READ) begin
            res_d.kind = KIND_READ;
            emit_d     = 1'b1;
            state_d    = S_IDLE;
          end else begin
            res_d.kind = KIND_DUMP;
            res_d.pos  = POS_W'(idx_q);
            res_d.last = (idx_p1 == cnt_x);
            emit_d     = 1'b1;
            state_d    = S_IDLE;
          end
        end
        S_SH_RD: begin
          mem_req_o.raddr = idx_inc[ADDR_W-1:0];
          state_d         = S_SH_WR;
        end
        S_SH_WR: begin
          mem_req_o.we = 1'b1;
          idx_d        = idx_inc;
          if (idx_p2 < cnt_x) begin
            state_d = S_SH_RD;
          end else begin
            count_d = count_q - CNT_W'(1);
            emit_d  = 1'b1;
            state_d = S_IDLE;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      emit_q  <= 1'b0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count exceeds the store depth");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + CNT_W'(1)) || (count_q + CNT_W'(1) == $past(count_q))))
    else $error("entry count moved by more than one");

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_IDLE) || emit_q) |-> (idx_q <= count_q))
    else $error("walk index ran past the entry count");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q && out_free_i && res_q.last) |=> in_ready_o)
    else $error("sequencer kept working after the final result");

endmodule

>>> src/indexed_list_buffer.sv
// Top level of the positional insert/delete list buffer with its output register.
// An insert at the end writes at once; another insert moves each entry from the end down to its
// position up one slot, then writes the item. A delete fetches the entry, moves later ones down
// and returns it; a read fetches and returns one entry. A dump returns every entry in turn,
// waiting while the output side is full. Reset empties the list. The single read port sets the
// pace: a shifted entry costs a read and a write step, so a full dump is the longest item.
module indexed_list_buffer
  import ilb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               mode_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] item_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [KIND_W-1:0]        kind_o,
  output logic [POS_W-1:0]         echo_position_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic                     last_o
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] rdata;
  logic              res_valid;
  res_t              res;
  logic              out_free;
  logic              out_valid_q, out_valid_d;
  res_t              out_q;

  // The output register can take a new result when it is empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  ilb_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  ilb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .mem_req_o    (mem_req),
    .rdata_i      (rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload needs no reset; it is only looked at while valid is high.
  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign echo_position_o = out_q.pos;
  assign result_value_o  = out_q.value;
  assign last_o          = out_q.last;

endmodule

>>> tb/list_check_pkg.sv
// Scoreboard class that predicts and checks the results of the list buffer.
`timescale 1ns / 100ps

package list_check_pkg;
  import ilb_pkg::*;

  class list_scoreboard;
    logic signed [DATA_W-1:0] entries [DEPTH];
    int unsigned              fill;
    res_t                     awaited [$];
    int unsigned              errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void queue_result(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                               logic signed [DATA_W-1:0] v, logic l);
      res_t r;
      r.kind  = k;
      r.pos   = p;
      r.value = v;
      r.last  = l;
      awaited.push_back(r);
    endfunction

    // Applies one accepted request to the predicted list and queues its results.
    function void note_request(logic [1:0] m, logic [POS_W-1:0] p,
                               logic signed [DATA_W-1:0] v);
      logic signed [DATA_W-1:0] removed;
      case (m)
        MODE_INSERT: begin
          if (p > fill || fill >= DEPTH) begin
            queue_result(KIND_INS_REJ, p, '0, 1'b1);
          end else begin
            for (int unsigned i = fill; i > p; i--) entries[i] = entries[i-1];
            entries[p] = v;
            fill++;
          end
        end
        MODE_DELETE: begin
          if (p >= fill) begin
            queue_result(KIND_DEL_REJ, p, '0, 1'b1);
          end else begin
            removed = entries[p];
            for (int unsigned i = p; i + 1 < fill; i++) entries[i] = entries[i+1];
            fill--;
            queue_result(KIND_DELETED, p, removed, 1'b1);
          end
        end
        MODE_READ: begin
          if (p >= fill) queue_result(KIND_READ_BAD, p, '0, 1'b1);
          else queue_result(KIND_READ, p, entries[p], 1'b1);
        end
        default: begin
          if (fill == 0) begin
            queue_result(KIND_EMPTY, '0, '0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++) begin
              queue_result(KIND_DUMP, i[POS_W-1:0], entries[i], (i + 1 == fill));
            end
          end
        end
      endcase
    endfunction

    task check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result kind %0d pos %0d value %0h last %0b",
                         got.kind, got.pos, got.value, got.last));
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
      if (got.pos !== want.pos)
        report($sformatf("echo_position %0d, wanted %0d", got.pos, want.pos));
      if (got.value !== want.value)
        report($sformatf("result_value %h, wanted %h", got.value, want.value));
      if (got.last !== want.last)
        report($sformatf("last %b, wanted %b", got.last, want.last));
    endtask
  endclass

endpackage

>>> tb/testbench.sv
// Self-checking testbench of the positional insert/delete list buffer.
`timescale 1ns / 100ps

module testbench;
  import ilb_pkg::*;
  import list_check_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 480;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // The longest single request is a dump of the full list.
  localparam int unsigned DRAIN_CYCLES    = 3 * DEPTH + 8;

  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               mode_i       = MODE_INSERT;
  logic [POS_W-1:0]         position_i   = '0;
  logic signed [DATA_W-1:0] item_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic [KIND_W-1:0]        kind_o;
  logic [POS_W-1:0]         echo_position_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic                     last_o;

  // The scoreboard holds its own copy of the list and the results still awaited.
  list_scoreboard sb = new();

  // Pacing controls. The eager flag switches sender idling off for whole stretches so that
  // back-to-back traffic is covered as well as random gaps.
  bit          sender_eager   = 1'b0;
  bit          random_phase   = 1'b0;
  bit          hold_off       = 1'b0;
  int unsigned stall_left     = 0;
  int unsigned stall_drawn    = 0;
  int unsigned results_seen   = 0;

  always #5 clk_i = ~clk_i;

  indexed_list_buffer i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .kind_o          (kind_o),
    .echo_position_o (echo_position_o),
    .result_value_o  (result_value_o),
    .last_o          (last_o)
  );

  // Offers one request after a random gap and holds it until the block takes it.
  // The prediction is updated at the accepting edge, so the list state seen by the
  // stimulus generator is always that of every request accepted so far.
  task automatic send_request(input logic [1:0] m, input logic [POS_W-1:0] p,
                              input logic signed [DATA_W-1:0] v);
    int unsigned gap;
    gap = sender_eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    position_i   <= p;
    item_value_i <= v;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_request(m, p, v);
  endtask

  // Mostly random values, with the signed extremes and the all-zero and all-one
  // patterns mixed in now and then.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return VALUE_MIN;
      1:       return VALUE_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Picks a random request. Most positions are legal for the current list so that
  // the shifting paths get exercised; about one in ten is drawn over the whole range.
  // The list alternates between a growing and a shrinking phase so that it passes
  // through every fill level, the empty and the full list included.
  task automatic send_random_request(input int unsigned idx);
    int unsigned      roll;
    int unsigned      grow_limit;
    logic [1:0]       m;
    logic [POS_W-1:0] p;
    roll       = $urandom_range(0, 99);
    grow_limit = ((idx / 48) % 2 == 0) ? 55 : 20;
    if (roll < grow_limit) m = MODE_INSERT;
    else if (roll < grow_limit + 23) m = MODE_DELETE;
    else if (roll < 92) m = MODE_READ;
    else m = MODE_DUMP;

    if (m == MODE_DUMP || $urandom_range(0, 9) == 0) begin
      p = POS_W'($urandom_range(0, 31));
    end else if (m == MODE_INSERT) begin
      p = POS_W'($urandom_range(0, sb.fill));
    end else begin
      p = (sb.fill == 0) ? '0 : POS_W'($urandom_range(0, sb.fill - 1));
    end
    send_request(m, p, pick_value());
  endtask

  // Stimulus: reset, a directed pass over the corner cases, then the random stream.
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every command on the empty list: read, delete and dump all have their own
    // reject or empty answers, and an insert past the end is refused.
    send_request(MODE_READ,   5'd0,  '0);
    send_request(MODE_DELETE, 5'd0,  VALUE_MAX);
    send_request(MODE_DUMP,   5'd17, '0);
    send_request(MODE_INSERT, 5'd1,  VALUE_MAX);
    send_request(MODE_INSERT, 5'd31, VALUE_MIN);

    // Fill the list to capacity, inserting at the front, the end and the middle in
    // turn, with extreme values among the data.
    for (int unsigned k = 0; k < DEPTH; k++) begin
      logic [POS_W-1:0]         p;
      logic signed [DATA_W-1:0] v;
      case (k % 3)
        0:       p = '0;
        1:       p = POS_W'(sb.fill);
        default: p = POS_W'(sb.fill / 2);
      endcase
      case (k % 5)
        0:       v = VALUE_MIN;
        1:       v = VALUE_MAX;
        2:       v = '1;
        3:       v = '0;
        default: v = $urandom();
      endcase
      send_request(MODE_INSERT, p, v);
    end

    // A full list refuses even a legal position; then the last slot, one past it,
    // a complete dump, and deletes at both ends.
    send_request(MODE_INSERT, 5'd5,  32'sh1234_5678);
    send_request(MODE_READ,   5'd15, '0);
    send_request(MODE_READ,   5'd16, '0);
    send_request(MODE_DUMP,   5'd0,  '0);
    send_request(MODE_DELETE, 5'd0,  '0);
    send_request(MODE_DELETE, 5'd15, '0);
    send_request(MODE_DELETE, 5'd14, '0);

    random_phase = 1'b1;
    for (int unsigned idx = 0; idx < RANDOM_REQUESTS; idx++) begin
      sender_eager = ((idx / 40) % 3 == 1);
      send_random_request(idx);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait for every awaited result, then give the block time to show any result it
    // should not produce, for instance after a trailing successful insert.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Back-pressure: once the random stream starts the receiver refuses results for a
  // long stretch, while the sender keeps offering, so the block has to stall its input.
  initial begin
    wait (random_phase);
    @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Receiver side of the result channel; a stall count is drawn after each accepted
  // result and counted down here by one at each falling edge.
  // Every third stretch of fifty results runs with no receiver stalls at all.
  always @(negedge clk_i) begin
    if (stall_drawn != results_seen) begin
      stall_drawn = results_seen;
      stall_left  = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 3);
    end
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  = stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result monitor: every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.kind  = kind_o;
      got.pos   = echo_position_o;
      got.value = result_value_o;
      got.last  = last_o;
      sb.check_result(got);
      results_seen++;
    end
  end

  // Watchdog: far beyond the slowest legal run, including the hold-off stretch.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
